### hw/rtl/vce_pkg.sv
// Shared types and constants for the vector clock engine.
`timescale 1ns / 1ps

package vce_pkg;

  localparam int MaxProcs = 16;
  localparam int CntW     = 32;
  localparam int PidW     = $clog2(MaxProcs);
  localparam int NumW     = PidW + 1;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MERGE = 2'd1,
    KIND_CMP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ORDER_EQUAL      = 2'd0,
    ORDER_BEFORE     = 2'd1,
    ORDER_AFTER      = 2'd2,
    ORDER_CONCURRENT = 2'd3
  } order_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_OWN_PID   = 1'b0,
    REG_NUM_PROCS = 1'b1
  } reg_e;

  typedef struct packed {
    logic [PidW-1:0] own_pid;
    logic [NumW-1:0] num_procs;
  } cfg_t;

endpackage

### hw/rtl/vce_apb_regs.sv
// APB register block for the vector clock engine configuration.
`timescale 1ns / 1ps

module vce_apb_regs import vce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_OWN_PID:   cfg_d.own_pid   = pwdata[PidW-1:0];
        REG_NUM_PROCS: cfg_d.num_procs = pwdata[NumW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_OWN_PID:   prdata = {{(32-PidW){1'b0}}, cfg_q.own_pid};
      REG_NUM_PROCS: prdata = {{(32-NumW){1'b0}}, cfg_q.num_procs};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_pid   <= '0;
      cfg_q.num_procs <= NumW'(MaxProcs);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/vector_clock_engine_top.sv
// Vector clock engine: counter memory, merge/tick update and compare stream.
// Flow: an accepted beat is read from the counter memory into rdata_q and written back
// from stage 2; a final compare beat's result is registered as it leaves stage 2.
// A new beat waits while stage 2 is busy, set by the single read-then-write pass over the
// counter memory. Reset restores config defaults, clears the nonzero and seen masks and sets
// the compare flags; counter entries read as zero until written, so no clearing pass.
`timescale 1ns / 1ps

module vector_clock_engine_top import vce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // config
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // input beats
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      kind_i,
  input  logic [PidW-1:0] entry_pid_i,
  input  logic [CntW-1:0] entry_count_i,
  input  logic            last_i,
  // results
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      order_o
);

  cfg_t cfg;

  vce_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Counter memory, one entry per process id
  logic [CntW-1:0] cnt_mem [MaxProcs];
  logic [CntW-1:0] rdata_q;

  logic            in_acc;
  kind_e           in_kind;
  logic [PidW-1:0] rd_addr;

  logic            s2_valid_q, s2_valid_d;
  kind_e           s2_kind_q;
  logic [PidW-1:0] s2_pid_q;
  logic [CntW-1:0] s2_cnt_q;
  logic            s2_last_q;
  logic            s2_inrange_q;

  logic [MaxProcs-1:0] nz_q, nz_d;
  logic [MaxProcs-1:0] seen_q, seen_d;
  logic                lle_q, lle_d;
  logic                ole_q, ole_d;

  logic                out_valid_q, out_valid_d;
  order_e              order_q, order_d;

  logic [CntW-1:0]     stored;
  logic [CntW-1:0]     wr_data;
  logic                wr_en;
  logic                s2_final;
  logic                s2_fire;
  logic                cmp_hit;
  logic [MaxProcs-1:0] in_use;
  logic [MaxProcs-1:0] seen_upd;
  logic                lle_upd, ole_upd, lle_fin;

  assign in_kind    = kind_e'(kind_i);
  assign in_stall_o = s2_valid_q;
  assign in_acc     = in_valid_i && !s2_valid_q;
  assign rd_addr    = (in_kind == KIND_TICK) ? cfg.own_pid : entry_pid_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= cnt_mem[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[s2_pid_q] <= wr_data;
    end
  end

  // Stage 2 payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_kind_q    <= in_kind;
      s2_pid_q     <= rd_addr;
      s2_cnt_q     <= entry_count_i;
      s2_last_q    <= last_i;
      s2_inrange_q <= {1'b0, entry_pid_i} < cfg.num_procs;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxProcs; i++) begin
      in_use[i] = NumW'(i) < cfg.num_procs;
    end
  end

  // Entries never written hold stale data; the nonzero mask doubles as valid
  assign stored   = nz_q[s2_pid_q] ? rdata_q : '0;
  assign s2_final = (s2_kind_q == KIND_CMP) && s2_last_q;
  assign s2_fire  = s2_valid_q && !(s2_final && out_valid_q && out_stall_i);
  assign cmp_hit  = (s2_kind_q == KIND_CMP) && s2_inrange_q && !seen_q[s2_pid_q];

  assign seen_upd = cmp_hit ? (seen_q | (MaxProcs'(1) << s2_pid_q)) : seen_q;
  assign lle_upd  = lle_q && !(cmp_hit && (stored > s2_cnt_q));
  assign ole_upd  = ole_q && !(cmp_hit && (s2_cnt_q > stored));
  // Ids missing from the other clock count as zero there
  assign lle_fin  = lle_upd && !(|(~seen_upd & nz_q & in_use));

  always_comb begin
    wr_en       = 1'b0;
    wr_data     = stored;
    nz_d        = nz_q;
    seen_d      = seen_q;
    lle_d       = lle_q;
    ole_d       = ole_q;
    out_valid_d = out_valid_q && out_stall_i;
    order_d     = order_q;
    if (s2_fire) begin
      unique case (s2_kind_q)
        KIND_TICK: begin
          wr_en          = 1'b1;
          wr_data        = (stored == CntMax) ? stored : stored + CntW'(1);
          nz_d[s2_pid_q] = 1'b1;
        end
        KIND_MERGE: begin
          if (s2_inrange_q && (s2_cnt_q > stored)) begin
            wr_en          = 1'b1;
            wr_data        = s2_cnt_q;
            nz_d[s2_pid_q] = 1'b1;
          end
        end
        KIND_CMP: begin
          if (s2_last_q) begin
            out_valid_d = 1'b1;
            priority if (lle_fin && ole_upd) order_d = ORDER_EQUAL;
            else if (lle_fin)                order_d = ORDER_BEFORE;
            else if (ole_upd)                order_d = ORDER_AFTER;
            else                             order_d = ORDER_CONCURRENT;
            seen_d = '0;
            lle_d  = 1'b1;
            ole_d  = 1'b1;
          end else begin
            seen_d = seen_upd;
            lle_d  = lle_upd;
            ole_d  = ole_upd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (in_acc) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      nz_q        <= '0;
      seen_q      <= '0;
      lle_q       <= 1'b1;
      ole_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      nz_q        <= nz_d;
      seen_q      <= seen_d;
      lle_q       <= lle_d;
      ole_q       <= ole_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q <= order_d;
  end

  assign out_valid_o = out_valid_q;
  assign order_o     = order_q;

`ifndef SYNTH
  a_rise_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s2_valid_q && s2_final))
    else $error("result raised without a final compare beat");

  a_stream_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_final) |=> (seen_q == '0) && lle_q && ole_q)
    else $error("compare stream state not cleared after final beat");

  a_nz_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((nz_q & $past(nz_q)) == $past(nz_q)))
    else $error("nonzero mask lost a bit");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_fire) |=> s2_valid_q && $stable(s2_pid_q))
    else $error("blocked beat left stage 2");
`endif

endmodule

### test/vce_order_checker.sv
// Checker for the vector clock engine: tracks the clock, predicts compare orders, scores results.
`timescale 1ns / 1ps

module vce_order_checker import vce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [1:0]      kind_i,
  input  logic [PidW-1:0] entry_pid_i,
  input  logic [CntW-1:0] entry_count_i,
  input  logic            last_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [1:0]      order_i,
  output int              mismatches_o,
  output int              pending_o
);

  logic [PidW-1:0] cfg_own;
  logic [NumW-1:0] cfg_num;

  logic [CntW-1:0] vc_count [MaxProcs];
  logic            vc_live  [MaxProcs];
  logic            cmp_seen [MaxProcs];
  logic            local_le;
  logic            remote_le;

  order_e expected_orders [$];
  int     mism;

  task automatic clear_compare();
    for (int i = 0; i < MaxProcs; i++) cmp_seen[i] = 1'b0;
    local_le  = 1'b1;
    remote_le = 1'b1;
  endtask

  task automatic apply_clock_beat(input logic [1:0] kind, input logic [PidW-1:0] pid,
                                  input logic [CntW-1:0] cnt, input logic last);
    int     n;
    order_e ord;
    n = (cfg_num > MaxProcs) ? MaxProcs : int'(cfg_num);
    case (kind)
      KIND_TICK: begin
        if (int'(cfg_own) < MaxProcs) begin
          if (vc_count[cfg_own] != CntMax) vc_count[cfg_own] = vc_count[cfg_own] + CntW'(1);
          vc_live[cfg_own] = 1'b1;
        end
      end
      KIND_MERGE: begin
        if (int'(pid) < n && cnt > vc_count[pid]) begin
          vc_count[pid] = cnt;
          vc_live[pid]  = 1'b1;
        end
      end
      KIND_CMP: begin
        // only the first entry for an id in a stream counts
        if (int'(pid) < n && !cmp_seen[pid]) begin
          cmp_seen[pid] = 1'b1;
          if (vc_count[pid] > cnt) local_le = 1'b0;
          if (cnt > vc_count[pid]) remote_le = 1'b0;
        end
        if (last) begin
          // ids absent from the other clock read as zero there
          for (int i = 0; i < n; i++) begin
            if (!cmp_seen[i] && vc_live[i]) local_le = 1'b0;
          end
          if (local_le && remote_le) ord = ORDER_EQUAL;
          else if (local_le)         ord = ORDER_BEFORE;
          else if (remote_le)        ord = ORDER_AFTER;
          else                       ord = ORDER_CONCURRENT;
          expected_orders.push_back(ord);
          clear_compare();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    order_e want;
    if (!rst_ni) begin
      cfg_own = '0;
      cfg_num = NumW'(MaxProcs);
      for (int i = 0; i < MaxProcs; i++) begin
        vc_count[i] = '0;
        vc_live[i]  = 1'b0;
      end
      clear_compare();
      expected_orders.delete();
      mism = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_orders.size() == 0) begin
          if (mism < 10) $display("%0t: unexpected result beat, order %0d", $realtime, order_i);
          mism++;
        end else begin
          want = expected_orders.pop_front();
          if (order_i !== want) begin
            if (mism < 10)
              $display("%0t: order mismatch: expected %0d got %0d", $realtime, want, order_i);
            mism++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[2]))
          REG_OWN_PID:   cfg_own = pwdata[PidW-1:0];
          REG_NUM_PROCS: cfg_num = pwdata[NumW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        apply_clock_beat(kind_i, entry_pid_i, entry_count_i, last_i);
      pending_o    <= expected_orders.size();
      mismatches_o <= mism;
    end
  end

endmodule

### test/vector_clock_engine_top_tb.sv
// Testbench top for the vector clock engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module vector_clock_engine_top_tb;
  import vce_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      kind_i = '0;
  logic [PidW-1:0] entry_pid_i = '0;
  logic [CntW-1:0] entry_count_i = '0;
  logic            last_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [1:0]      order_o;

  logic calm = 1'b0;
  int   hold_left = 0;
  int   mismatch_n;
  int   pending_n;

  vector_clock_engine_top DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .kind_i, .entry_pid_i, .entry_count_i, .last_i,
    .out_valid_o, .out_stall_i, .order_o
  );

  vce_order_checker checker_i (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_i (in_stall_o), .kind_i, .entry_pid_i, .entry_count_i, .last_i,
    .out_valid_i (out_valid_o), .out_stall_i, .order_i (order_o),
    .mismatches_o (mismatch_n), .pending_o (pending_n)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // result side backpressure: short random stalls plus an occasional long one
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_left   <= $urandom_range(5, 20);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 13);
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic [PidW-1:0] pid,
                           input logic [CntW-1:0] cnt, input logic last);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    entry_pid_i   <= pid;
    entry_count_i <= cnt;
    last_i        <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain: no beat in flight and every order received
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_n != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly tiny counts so compares land on equal/before/after, some extremes
  function automatic logic [CntW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CntW'($urandom_range(0, 3));
    if (r < 85) return CntW'($urandom_range(0, 40));
    if (r < 92) return CntMax - CntW'($urandom_range(0, 2));
    return CntW'($urandom());
  endfunction

  function automatic logic [PidW-1:0] pick_pid(input int n);
    if (n > 0 && $urandom_range(0, 9) != 0) return PidW'($urandom_range(0, n - 1));
    return PidW'($urandom_range(0, MaxProcs - 1));
  endfunction

  task automatic run_phase(input int own, input int num, input int beats, input logic quiet);
    int eff;
    int sent;
    int r;
    int len;
    write_reg(REG_OWN_PID, own);
    write_reg(REG_NUM_PROCS, num);
    calm <= quiet;
    eff  = (num > MaxProcs) ? MaxProcs : num;
    sent = 0;
    while (sent < beats) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_beat(KIND_TICK, PidW'($urandom_range(0, 15)), CntW'($urandom()),
                  1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 35) begin
        send_beat(KIND_MERGE, pick_pid(eff), pick_count(), 1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 40) begin
        // unused kind, ignored by the block
        send_beat(2'd3, PidW'($urandom_range(0, 15)), CntW'($urandom()),
                  1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_beat($urandom_range(0, 1) ? KIND_TICK : KIND_MERGE, pick_pid(eff),
                      pick_count(), 1'b0);
            sent++;
          end
          send_beat(KIND_CMP, pick_pid(eff), pick_count(), k == len - 1);
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty other clock against an all-zero local clock
    send_beat(KIND_CMP, 4'd0, '0, 1'b1);
    send_beat(KIND_TICK, 4'hF, CntMax, 1'b0);
    send_beat(KIND_TICK, 4'd0, '0, 1'b1);
    send_beat(KIND_MERGE, 4'd15, CntMax, 1'b0);
    send_beat(KIND_MERGE, 4'd3, 32'd5, 1'b1);
    send_beat(KIND_MERGE, 4'd3, 32'd2, 1'b0);
    // exact match, with a repeated id that must not count
    send_beat(KIND_CMP, 4'd0, 32'd2, 1'b0);
    send_beat(KIND_CMP, 4'd3, 32'd5, 1'b0);
    send_beat(KIND_CMP, 4'd0, 32'd100, 1'b0);
    send_beat(KIND_CMP, 4'd15, CntMax, 1'b1);
    send_beat(KIND_CMP, 4'd0, 32'd3, 1'b1);
    send_beat(KIND_CMP, 4'd0, '0, 1'b1);
    send_beat(KIND_CMP, 4'd0, 32'd9, 1'b0);
    send_beat(KIND_CMP, 4'd3, 32'd9, 1'b0);
    send_beat(KIND_CMP, 4'd15, CntMax, 1'b1);
    send_beat(2'd3, 4'hF, CntMax, 1'b1);
    settle();
    // tick on a saturated counter
    write_reg(REG_OWN_PID, 32'd15);
    send_beat(KIND_TICK, 4'd0, '0, 1'b0);
    send_beat(KIND_TICK, 4'd0, '0, 1'b0);
    settle();
    write_reg(REG_OWN_PID, 32'd3);
    // compare stream split by a register write
    send_beat(KIND_CMP, 4'd5, '0, 1'b0);
    settle();
    write_reg(REG_NUM_PROCS, 32'd4);
    send_beat(KIND_CMP, 4'd0, 32'd2, 1'b1);
    settle();
    write_reg(REG_NUM_PROCS, 32'd0);
    send_beat(KIND_CMP, 4'd0, 32'd7, 1'b1);
    send_beat(KIND_MERGE, 4'd0, 32'd9, 1'b0);
    settle();
    // out-of-range id still ends the stream
    write_reg(REG_NUM_PROCS, 32'd1);
    send_beat(KIND_CMP, 4'd5, 32'd99, 1'b1);
    settle();
    write_reg(REG_NUM_PROCS, 32'd31);
    send_beat(KIND_CMP, 4'd15, CntMax, 1'b1);
    settle();

    run_phase(0, 16, 300, 1'b1);
    run_phase(15, 1, 300, 1'b0);
    run_phase($urandom_range(0, 15), $urandom_range(2, 4), 300, 1'b0);
    run_phase($urandom_range(0, 15), 0, 300, 1'b0);
    run_phase($urandom_range(0, 15), 31, 300, 1'b0);
    run_phase($urandom_range(0, 15), $urandom_range(0, 31), 300, 1'b0);

    repeat (8) @(posedge clk_i);
    if (mismatch_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/vce_pkg.sv
hw/rtl/vce_apb_regs.sv
hw/rtl/vector_clock_engine_top.sv
test/vce_order_checker.sv
test/vector_clock_engine_top_tb.sv
